// ----- hdl/trs_pkg.sv -----
// shared types and constants for the track request scheduler
// no dependencies
package trs_pkg;

   localparam int DEF_QUEUE_DEPTH = 32;
   localparam int DEF_TRACK_BITS  = 12;
   localparam int DEF_TAG_BITS    = 8;
   localparam int MODE_BITS       = 3;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_PICK   = 2'd1,
      OP_HEAD   = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   localparam logic [MODE_BITS-1:0] POL_FIFO  = 3'd0;
   localparam logic [MODE_BITS-1:0] POL_SSTF  = 3'd1;
   localparam logic [MODE_BITS-1:0] POL_LOOK  = 3'd2;
   localparam logic [MODE_BITS-1:0] POL_CLOOK = 3'd3;
   localparam logic [MODE_BITS-1:0] POL_FLOOK = 3'd4;

   localparam logic CSR_ADDR_MODE = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_TAKE_NEXT,
      CELL_LOAD
   } cell_op_type;

   // candidate trackers
   localparam int TRK_FIFO = 0;
   localparam int TRK_SSTF = 1;
   localparam int TRK_UP   = 2;
   localparam int TRK_DN   = 3;
   localparam int TRK_MIN  = 4;
   localparam int TRK_B0U  = 5;
   localparam int TRK_B0D  = 6;
   localparam int TRK_B1U  = 7;
   localparam int TRK_B1D  = 8;
   localparam int NUM_TRK  = 9;

   typedef logic [3:0] trk_sel_type;

   typedef struct packed {
      logic found;
      logic new_dir;
      logic new_act;
   } decision_type;

endpackage

// ----- hdl/track_request_scheduler.sv -----
// track request scheduler: insert and set-head are handled in the idle state, the result
// strobe follows on the next cycle and busy stays low.
// pick: the scan state rotates the whole slot chain past the selector, then the
// decide state commits the choice, and the result strobe follows the cycle after.
// reset (synchronous) empties the queue, clears head, direction, batch, mode.
// results are strobed for one cycle and cannot be stalled.
module track_request_scheduler import trs_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int TRACK_BITS  = DEF_TRACK_BITS,
   parameter int TAG_BITS    = DEF_TAG_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_opcode,
   input  logic [TAG_BITS-1:0]   req_request_id,
   input  logic [TRACK_BITS-1:0] req_request_track,
   input  logic [TRACK_BITS-1:0] req_head_track_in,
   input  logic                  req_head_dir_in,
   output logic                  rsp_valid,
   output logic                  rsp_granted,
   output logic [TAG_BITS-1:0]   rsp_grant_id,
   output logic [TRACK_BITS-1:0] rsp_grant_track,
   output logic                  rsp_sweep_dir_out,
   output logic                  rsp_queue_empty,
   output logic                  rsp_overflow,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [0:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   state_type             state_ff, state_in;
   logic [MODE_BITS-1:0]  mode_ff;
   logic [TRACK_BITS-1:0] head_ff, head_in;
   logic                  dir_ff, dir_in, act_ff, act_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [IDX_BITS-1:0]   pos_ff, pos_in;
   logic                  rv_ff, rv_in, rg_ff, rg_in, ro_ff, ro_in;
   logic [TAG_BITS-1:0]   rid_ff, rid_in;
   logic [TRACK_BITS-1:0] rtr_ff, rtr_in;

   logic accept, is_insert, is_pick, full, last_pos;
   decision_type          dec;
   logic [IDX_BITS-1:0]   sel_idx;
   logic [TAG_BITS-1:0]   sel_tag;
   logic [TRACK_BITS-1:0] sel_track;

   logic [TAG_BITS-1:0]   c_tag   [QUEUE_DEPTH];
   logic [TRACK_BITS-1:0] c_track [QUEUE_DEPTH];
   logic                  c_batch [QUEUE_DEPTH];
   cell_op_type           c_op    [QUEUE_DEPTH];

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_ADDR_MODE) ? {{(32-MODE_BITS){1'b0}}, mode_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= POL_FIFO;
      end else if (psel && penable && pwrite && paddr == CSR_ADDR_MODE) begin
         mode_ff <= pwdata[MODE_BITS-1:0];
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign accept    = start && !busy;
   assign is_insert = opcode_type'(req_opcode) == OP_INSERT;
   assign is_pick   = opcode_type'(req_opcode) == OP_PICK;
   assign full      = cnt_ff == CNT_BITS'(QUEUE_DEPTH);
   assign last_pos  = pos_ff == IDX_BITS'(QUEUE_DEPTH - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept && is_pick) state_in = ST_SCAN;
         ST_SCAN:   if (last_pos) state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      head_in = head_ff;
      dir_in  = dir_ff;
      act_in  = act_ff;
      cnt_in  = cnt_ff;
      pos_in  = pos_ff;
      rv_in   = 1'b0;
      rg_in   = 1'b0;
      ro_in   = 1'b0;
      rid_in  = '0;
      rtr_in  = '0;
      case (state_ff)
         ST_IDLE: begin
            pos_in = '0;
            if (accept) begin
               rv_in = !is_pick;
               case (opcode_type'(req_opcode))
                  OP_INSERT: begin
                     if (full) ro_in = 1'b1;
                     else cnt_in = cnt_ff + 1'b1;
                  end
                  OP_HEAD: begin
                     head_in = req_head_track_in;
                     dir_in  = req_head_dir_in;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: pos_in = pos_ff + 1'b1;
         ST_DECIDE: begin
            rv_in  = 1'b1;
            dir_in = dec.new_dir;
            act_in = dec.new_act;
            if (dec.found) begin
               rg_in  = 1'b1;
               rid_in = sel_tag;
               rtr_in = sel_track;
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         dir_ff   <= 1'b0;
         act_ff   <= 1'b0;
         cnt_ff   <= '0;
         pos_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         dir_ff   <= dir_in;
         act_ff   <= act_in;
         cnt_ff   <= cnt_in;
         pos_ff   <= pos_in;
         rv_ff    <= rv_in;
      end
      rg_ff  <= rg_in;
      ro_ff  <= ro_in;
      rid_ff <= rid_in;
      rtr_ff <= rtr_in;
   end

   assign rsp_valid         = rv_ff;
   assign rsp_granted       = rg_ff;
   assign rsp_grant_id      = rid_ff;
   assign rsp_grant_track   = rtr_ff;
   assign rsp_overflow      = ro_ff;
   assign rsp_sweep_dir_out = dir_ff;
   assign rsp_queue_empty   = cnt_ff == '0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      localparam int NXT = (i + 1) % QUEUE_DEPTH;

      always_comb begin
         c_op[i] = CELL_HOLD;
         case (state_ff)
            ST_IDLE:
               if (accept && is_insert && !full && cnt_ff == CNT_BITS'(i)) c_op[i] = CELL_LOAD;
            ST_SCAN: c_op[i] = CELL_TAKE_NEXT;
            ST_DECIDE:
               if (dec.found && IDX_BITS'(i) >= sel_idx && CNT_BITS'(i + 1) < cnt_ff)
                  c_op[i] = CELL_TAKE_NEXT;
            default: ;
         endcase
      end

      trs_cell #(
         .TRACK_BITS(TRACK_BITS),
         .TAG_BITS  (TAG_BITS)
      ) u_cell (
         .clock     (clock),
         .op        (c_op[i]),
         .next_tag  (c_tag[NXT]),
         .next_track(c_track[NXT]),
         .next_batch(c_batch[NXT]),
         .load_tag  (req_request_id),
         .load_track(req_request_track),
         .load_batch((mode_ff == POL_FLOOK) ? !act_ff : act_ff),
         .tag       (c_tag[i]),
         .track     (c_track[i]),
         .batch     (c_batch[i])
      );
   end

   trs_select #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .TRACK_BITS (TRACK_BITS),
      .TAG_BITS   (TAG_BITS)
   ) u_select (
      .clock     (clock),
      .clear     (state_ff == ST_IDLE),
      .enable    (state_ff == ST_SCAN && CNT_BITS'(pos_ff) < cnt_ff),
      .position  (pos_ff),
      .cand_tag  (c_tag[0]),
      .cand_track(c_track[0]),
      .cand_batch(c_batch[0]),
      .head      (head_ff),
      .dir       (dir_ff),
      .act       (act_ff),
      .mode      (mode_ff),
      .decision  (dec),
      .sel_idx   (sel_idx),
      .sel_tag   (sel_tag),
      .sel_track (sel_track)
   );

endmodule

// ----- hdl/trs_cell.sv -----
// one slot of the request chain: holds tag, track and batch
// depends on trs_pkg
module trs_cell import trs_pkg::*; #(
   parameter int TRACK_BITS = DEF_TRACK_BITS,
   parameter int TAG_BITS   = DEF_TAG_BITS
) (
   input  logic                  clock,
   input  cell_op_type           op,
   input  logic [TAG_BITS-1:0]   next_tag,
   input  logic [TRACK_BITS-1:0] next_track,
   input  logic                  next_batch,
   input  logic [TAG_BITS-1:0]   load_tag,
   input  logic [TRACK_BITS-1:0] load_track,
   input  logic                  load_batch,
   output logic [TAG_BITS-1:0]   tag,
   output logic [TRACK_BITS-1:0] track,
   output logic                  batch
);

   logic [TAG_BITS-1:0]   tag_ff, tag_in;
   logic [TRACK_BITS-1:0] track_ff, track_in;
   logic                  batch_ff, batch_in;

   always_comb begin
      tag_in   = tag_ff;
      track_in = track_ff;
      batch_in = batch_ff;
      case (op)
         CELL_TAKE_NEXT: begin
            tag_in   = next_tag;
            track_in = next_track;
            batch_in = next_batch;
         end
         CELL_LOAD: begin
            tag_in   = load_tag;
            track_in = load_track;
            batch_in = load_batch;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      tag_ff   <= tag_in;
      track_ff <= track_in;
      batch_ff <= batch_in;
   end

   assign tag   = tag_ff;
   assign track = track_ff;
   assign batch = batch_ff;

endmodule

// ----- hdl/trs_select.sv -----
// candidate trackers fed by the chain head, and the policy decision
// depends on trs_pkg
module trs_select import trs_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int TRACK_BITS  = DEF_TRACK_BITS,
   parameter int TAG_BITS    = DEF_TAG_BITS,
   localparam int IDX_BITS   = $clog2(QUEUE_DEPTH)
) (
   input  logic                  clock,
   input  logic                  clear,
   input  logic                  enable,
   input  logic [IDX_BITS-1:0]   position,
   input  logic [TAG_BITS-1:0]   cand_tag,
   input  logic [TRACK_BITS-1:0] cand_track,
   input  logic                  cand_batch,
   input  logic [TRACK_BITS-1:0] head,
   input  logic                  dir,
   input  logic                  act,
   input  logic [MODE_BITS-1:0]  mode,
   output decision_type          decision,
   output logic [IDX_BITS-1:0]   sel_idx,
   output logic [TAG_BITS-1:0]   sel_tag,
   output logic [TRACK_BITS-1:0] sel_track
);

   logic [NUM_TRK-1:0]   v_ff;
   logic [TRACK_BITS-1:0] d_ff   [NUM_TRK];
   logic [IDX_BITS-1:0]   i_ff   [NUM_TRK];
   logic [TAG_BITS-1:0]   tg_ff  [NUM_TRK];
   logic [TRACK_BITS-1:0] tr_ff  [NUM_TRK];
   logic [NUM_TRK-1:0]   elig;
   logic [TRACK_BITS-1:0] cand_dist [NUM_TRK];
   logic                  is_up, is_dn;
   logic [TRACK_BITS-1:0] up_d, dn_d;

   always_comb begin
      is_up = cand_track >= head;
      is_dn = cand_track <= head;
      up_d  = cand_track - head;
      dn_d  = head - cand_track;
      elig[TRK_FIFO] = position == '0;
      cand_dist[TRK_FIFO] = '0;
      elig[TRK_SSTF] = 1'b1;
      cand_dist[TRK_SSTF] = is_up ? up_d : dn_d;
      elig[TRK_UP]   = is_up;
      cand_dist[TRK_UP]   = up_d;
      elig[TRK_DN]   = is_dn;
      cand_dist[TRK_DN]   = dn_d;
      elig[TRK_MIN]  = 1'b1;
      cand_dist[TRK_MIN]  = cand_track;
      elig[TRK_B0U]  = is_up && !cand_batch;
      cand_dist[TRK_B0U]  = up_d;
      elig[TRK_B0D]  = is_dn && !cand_batch;
      cand_dist[TRK_B0D]  = dn_d;
      elig[TRK_B1U]  = is_up && cand_batch;
      cand_dist[TRK_B1U]  = up_d;
      elig[TRK_B1D]  = is_dn && cand_batch;
      cand_dist[TRK_B1D]  = dn_d;
   end

   for (genvar t = 0; t < NUM_TRK; t++) begin : g_trk
      always_ff @(posedge clock) begin
         if (clear) begin
            v_ff[t] <= 1'b0;
         end else if (enable && elig[t] && (!v_ff[t] || cand_dist[t] < d_ff[t])) begin
            v_ff[t] <= 1'b1;
         end
         if (!clear && enable && elig[t] && (!v_ff[t] || cand_dist[t] < d_ff[t])) begin
            d_ff[t]  <= cand_dist[t];
            i_ff[t]  <= position;
            tg_ff[t] <= cand_tag;
            tr_ff[t] <= cand_track;
         end
      end
   end

   trk_sel_type sel, pri, alt;
   logic        flip, b, has_b0, has_b1, has_b;

   always_comb begin
      has_b0 = v_ff[TRK_B0U] | v_ff[TRK_B0D];
      has_b1 = v_ff[TRK_B1U] | v_ff[TRK_B1D];
      b      = (act ? has_b1 : has_b0) ? act : !act;
      has_b  = b ? has_b1 : has_b0;
      flip   = 1'b0;
      pri    = trk_sel_type'(TRK_FIFO);
      alt    = trk_sel_type'(TRK_FIFO);
      sel    = trk_sel_type'(TRK_FIFO);
      decision.new_act = act;
      case (mode)
         POL_SSTF: sel = trk_sel_type'(TRK_SSTF);
         POL_LOOK: begin
            pri  = dir ? trk_sel_type'(TRK_DN) : trk_sel_type'(TRK_UP);
            alt  = dir ? trk_sel_type'(TRK_UP) : trk_sel_type'(TRK_DN);
            flip = !v_ff[pri] && v_ff[alt];
            sel  = v_ff[pri] ? pri : alt;
         end
         POL_CLOOK: sel = v_ff[TRK_UP] ? trk_sel_type'(TRK_UP) : trk_sel_type'(TRK_MIN);
         POL_FLOOK: begin
            decision.new_act = b;
            if (b) begin
               pri = dir ? trk_sel_type'(TRK_B1D) : trk_sel_type'(TRK_B1U);
               alt = dir ? trk_sel_type'(TRK_B1U) : trk_sel_type'(TRK_B1D);
            end else begin
               pri = dir ? trk_sel_type'(TRK_B0D) : trk_sel_type'(TRK_B0U);
               alt = dir ? trk_sel_type'(TRK_B0U) : trk_sel_type'(TRK_B0D);
            end
            flip = has_b && !v_ff[pri];
            sel  = v_ff[pri] ? pri : alt;
         end
         default: sel = trk_sel_type'(TRK_FIFO);
      endcase
      decision.found   = v_ff[sel];
      decision.new_dir = dir ^ flip;
      sel_idx   = i_ff[sel];
      sel_tag   = tg_ff[sel];
      sel_track = tr_ff[sel];
   end

endmodule
